// ===== rtl/word_frequency_counter_assert.svh =====
// Assertion macros for the word frequency counter.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef WORD_FREQUENCY_COUNTER_ASSERT_SVH
`define WORD_FREQUENCY_COUNTER_ASSERT_SVH

// antecedent must be followed in the next cycle by the consequent
`define WFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies the consequent in the same cycle
`define WFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wfc_pkg.sv =====
// Shared types and constants for the word frequency counter.
// No dependencies.
package wfc_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 64;
    localparam int DEFAULT_MAX_WORD    = 30;

    localparam logic [7:0] DELIM_FIRST_RESET  = 8'd44;
    localparam logic [7:0] DELIM_SECOND_RESET = 8'd46;
    localparam logic [7:0] DELIM_THIRD_RESET  = 8'd32;
    localparam logic [7:0] NEWLINE_BYTE       = 8'h0A;
    localparam logic [7:0] UPPER_FIRST        = 8'h41;
    localparam logic [7:0] UPPER_LAST         = 8'h5A;
    localparam logic [7:0] LOWER_CASE_BIT     = 8'h20;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_SECOND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIM_THIRD  = 2'd2;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_ENTRY = 9'b000000010,
        ST_LEN   = 9'b000000100,
        ST_CMP   = 9'b000001000,
        ST_HIT   = 9'b000010000,
        ST_ALLOC = 9'b000100000,
        ST_COPY  = 9'b001000000,
        ST_FULL  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic take;
        logic start;
        logic entry_read;
        logic cmp_start;
        logic cmp_next;
        logic next_entry;
        logic hit;
        logic alloc;
        logic copy;
        logic full;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic close;
        logic at_end;
        logic room;
        logic len_match;
        logic char_match;
        logic last_char;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/word_frequency_counter.sv =====
// Word frequency counter: a byte stream is split into words and each word is counted.
// A byte that does not end a word is taken without stalling. At a word end the table
// is walked entry by entry, the stored length first and then each byte of an entry of
// equal length; a new word is appended byte by byte if there is room; then the result is
// handed out, all limited by the single read port of the stored-character memory.
// Depends on wfc_pkg, wfc_ctrl, wfc_datapath and word_frequency_counter_assert.svh.
`include "word_frequency_counter_assert.svh"

module word_frequency_counter
    import wfc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int MAX_WORD    = DEFAULT_MAX_WORD
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             text_byte,
    input  logic                   end_of_text,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [5:0]             entry_index,
    output logic [31:0]            entry_count,
    output logic                   is_new,
    output logic                   word_truncated,
    output logic                   table_full,
    output logic [31:0]            total_words
);

    cmd_t cmd;
    status_t status;

    wfc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    wfc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_WORD    (MAX_WORD)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .text_byte      (text_byte),
        .end_of_text    (end_of_text),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .entry_index    (entry_index),
        .entry_count    (entry_count),
        .is_new         (is_new),
        .word_truncated (word_truncated),
        .table_full     (table_full),
        .total_words    (total_words),
        .cmd            (cmd),
        .status         (status)
    );

    `WFC_ASSERT_NEXT(a_close_stalls, in_valid && !in_stall && status.close, in_stall, "word end did not start lookup")
    `WFC_ASSERT_NOW(a_rise_from_emit, $rose(out_valid), $past(cmd.emit), "result shown without emit")
    `WFC_ASSERT_NOW(a_new_not_full, out_valid, !(is_new && table_full), "new entry flagged with full table")

endmodule

// ===== rtl/wfc_ctrl.sv =====
// Controller state machine for the word frequency counter.
// Depends on wfc_pkg; drives commands to wfc_datapath.
module wfc_ctrl
    import wfc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (status.close)
                    begin
                        cmd.start = 1'b1;
                        state_next = ST_ENTRY;
                    end
                end
            end
            ST_ENTRY:
            begin
                if (status.at_end)
                begin
                    state_next = status.room ? ST_ALLOC : ST_FULL;
                end
                else
                begin
                    cmd.entry_read = 1'b1;
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                if (status.len_match)
                begin
                    cmd.cmp_start = 1'b1;
                    state_next = ST_CMP;
                end
                else
                begin
                    cmd.next_entry = 1'b1;
                    state_next = ST_ENTRY;
                end
            end
            ST_CMP:
            begin
                if (!status.char_match)
                begin
                    cmd.next_entry = 1'b1;
                    state_next = ST_ENTRY;
                end
                else if (status.last_char)
                begin
                    state_next = ST_HIT;
                end
                else
                begin
                    cmd.cmp_next = 1'b1;
                end
            end
            ST_HIT:
            begin
                cmd.hit = 1'b1;
                state_next = ST_DONE;
            end
            ST_ALLOC:
            begin
                cmd.alloc = 1'b1;
                state_next = ST_COPY;
            end
            ST_COPY:
            begin
                cmd.copy = 1'b1;
                if (status.last_char)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FULL:
            begin
                cmd.full = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/wfc_datapath.sv =====
// Datapath of the word frequency counter: word buffer, entry table, counters.
// Depends on wfc_pkg; steered by wfc_ctrl.
module wfc_datapath
    import wfc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int MAX_WORD    = DEFAULT_MAX_WORD
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic [7:0]             text_byte,
    input  logic                   end_of_text,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [5:0]             entry_index,
    output logic [31:0]            entry_count,
    output logic                   is_new,
    output logic                   word_truncated,
    output logic                   table_full,
    output logic [31:0]            total_words,
    input  cmd_t                   cmd,
    output status_t                status
);

    localparam int LW = $clog2(MAX_WORD + 1);
    localparam int WIW = $clog2(MAX_WORD);
    localparam int EW = $clog2(TABLE_DEPTH);
    localparam int UW = $clog2(TABLE_DEPTH + 1);
    localparam int CHAR_DEPTH = TABLE_DEPTH * MAX_WORD;
    localparam int CW = $clog2(CHAR_DEPTH);

    logic [7:0] delim_first_reg;
    logic [7:0] delim_second_reg;
    logic [7:0] delim_third_reg;

    logic [7:0] word_mem [MAX_WORD];
    logic [7:0] char_mem [CHAR_DEPTH];
    logic [LW-1:0] len_mem [TABLE_DEPTH];
    logic [31:0] cnt_mem [TABLE_DEPTH];

    logic [LW-1:0] len_reg;
    logic trunc_reg;
    logic [UW-1:0] used_reg;
    logic [31:0] total_reg;
    logic [UW-1:0] k_reg;
    logic [CW-1:0] base_reg;
    logic [LW-1:0] j_reg;

    logic [7:0] char_rdata;
    logic [LW-1:0] len_rdata;
    logic [31:0] cnt_rdata;

    logic [EW-1:0] res_idx_reg;
    logic [31:0] res_cnt_reg;
    logic res_new_reg;
    logic res_full_reg;

    logic out_valid_reg;
    logic [5:0] out_idx_reg;
    logic [31:0] out_cnt_reg;
    logic out_new_reg;
    logic out_trunc_reg;
    logic out_full_reg;
    logic [31:0] out_total_reg;

    logic [7:0] low_byte;
    logic is_delim;
    logic [CW-1:0] char_raddr;
    logic [CW-1:0] char_waddr;
    logic [LW-1:0] j_inc;
    logic [31:0] cnt_sat;
    logic cnt_we;
    logic [EW-1:0] cnt_waddr;
    logic [31:0] cnt_wdata;

    assign low_byte = (text_byte >= UPPER_FIRST && text_byte <= UPPER_LAST)
                      ? (text_byte | LOWER_CASE_BIT) : text_byte;
    assign is_delim = (low_byte == delim_first_reg) || (low_byte == delim_second_reg)
                      || (low_byte == delim_third_reg) || (low_byte == NEWLINE_BYTE);

    assign j_inc = LW'(j_reg + 1'b1);
    assign char_raddr = cmd.cmp_start ? base_reg : CW'(base_reg + CW'(j_inc));
    assign char_waddr = CW'(base_reg + CW'(j_reg));
    assign cnt_sat = (cnt_rdata == 32'hFFFF_FFFF) ? cnt_rdata : cnt_rdata + 32'd1;

    assign cnt_we = cmd.hit || cmd.alloc;
    assign cnt_waddr = cmd.hit ? k_reg[EW-1:0] : used_reg[EW-1:0];
    assign cnt_wdata = cmd.hit ? cnt_sat : 32'd1;

    assign status.close = is_delim ? (len_reg != '0) : end_of_text;
    assign status.at_end = (k_reg == used_reg);
    assign status.room = (used_reg < UW'(TABLE_DEPTH));
    assign status.len_match = (len_rdata == len_reg);
    assign status.char_match = (char_rdata == word_mem[j_reg[WIW-1:0]]);
    assign status.last_char = (j_inc == len_reg);
    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_first_reg <= DELIM_FIRST_RESET;
            delim_second_reg <= DELIM_SECOND_RESET;
            delim_third_reg <= DELIM_THIRD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DELIM_FIRST: delim_first_reg <= cfg_data;
                REG_DELIM_SECOND: delim_second_reg <= cfg_data;
                REG_DELIM_THIRD: delim_third_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            trunc_reg <= 1'b0;
            used_reg <= '0;
            total_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take && !is_delim)
            begin
                if (len_reg < LW'(MAX_WORD))
                begin
                    len_reg <= LW'(len_reg + 1'b1);
                end
                else
                begin
                    trunc_reg <= 1'b1;
                end
            end
            if (cmd.start && total_reg != 32'hFFFF_FFFF)
            begin
                total_reg <= total_reg + 32'd1;
            end
            if (cmd.alloc)
            begin
                used_reg <= UW'(used_reg + 1'b1);
            end
            if (cmd.emit)
            begin
                len_reg <= '0;
                trunc_reg <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && !is_delim && len_reg < LW'(MAX_WORD))
        begin
            word_mem[len_reg[WIW-1:0]] <= low_byte;
        end
        if (cmd.start)
        begin
            k_reg <= '0;
            base_reg <= '0;
            j_reg <= '0;
        end
        if (cmd.next_entry)
        begin
            k_reg <= UW'(k_reg + 1'b1);
            base_reg <= CW'(base_reg + CW'(MAX_WORD));
            j_reg <= '0;
        end
        if (cmd.cmp_next || cmd.copy)
        begin
            j_reg <= j_inc;
        end
        if (cmd.alloc)
        begin
            j_reg <= '0;
            len_mem[used_reg[EW-1:0]] <= len_reg;
        end
        if (cmd.entry_read)
        begin
            len_rdata <= len_mem[k_reg[EW-1:0]];
        end
        if (cmd.hit)
        begin
            res_idx_reg <= k_reg[EW-1:0];
            res_cnt_reg <= cnt_sat;
            res_new_reg <= 1'b0;
            res_full_reg <= 1'b0;
        end
        if (cmd.alloc)
        begin
            res_idx_reg <= used_reg[EW-1:0];
            res_cnt_reg <= 32'd1;
            res_new_reg <= 1'b1;
            res_full_reg <= 1'b0;
        end
        if (cmd.full)
        begin
            res_idx_reg <= '0;
            res_cnt_reg <= '0;
            res_new_reg <= 1'b0;
            res_full_reg <= 1'b1;
        end
        if (cmd.emit)
        begin
            out_idx_reg <= 6'(res_idx_reg);
            out_cnt_reg <= res_cnt_reg;
            out_new_reg <= res_new_reg;
            out_trunc_reg <= trunc_reg;
            out_full_reg <= res_full_reg;
            out_total_reg <= total_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.copy)
        begin
            char_mem[char_waddr] <= word_mem[j_reg[WIW-1:0]];
        end
        if (cmd.cmp_start || cmd.cmp_next)
        begin
            char_rdata <= char_mem[char_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cmd.entry_read)
        begin
            cnt_rdata <= cnt_mem[k_reg[EW-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign entry_index = out_idx_reg;
    assign entry_count = out_cnt_reg;
    assign is_new = out_new_reg;
    assign word_truncated = out_trunc_reg;
    assign table_full = out_full_reg;
    assign total_words = out_total_reg;

endmodule

// ===== tb/word_frequency_counter_test.sv =====
// Self-checking testbench for word_frequency_counter: drives bytes through the request
// channel, predicts each word result, and compares it field by field at the output.
// Depends on wfc_pkg and the word_frequency_counter RTL.
module word_frequency_counter_test;
    import wfc_pkg::*;

    localparam int DEPTH  = DEFAULT_TABLE_DEPTH;
    localparam int MAXLEN = DEFAULT_MAX_WORD;

    typedef struct packed {
        logic [5:0]  entry_index;
        logic [31:0] entry_count;
        logic        is_new;
        logic        word_truncated;
        logic        table_full;
        logic [31:0] total_words;
    } word_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_DELIM_FIRST;
    logic [7:0] cfg_data = 8'd0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [7:0] text_byte = 8'd0;
    logic end_of_text = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [5:0] entry_index;
    logic [31:0] entry_count;
    logic is_new, word_truncated, table_full;
    logic [31:0] total_words;

    word_frequency_counter dut (.*);

    always #5 clk = ~clk;

    // predictor state
    logic [7:0]  delim_a = DELIM_FIRST_RESET;
    logic [7:0]  delim_b = DELIM_SECOND_RESET;
    logic [7:0]  delim_c = DELIM_THIRD_RESET;
    logic [7:0]  pend_word [MAXLEN];
    int          pend_len = 0;
    logic        pend_cut = 1'b0;
    logic [7:0]  dict_chars [DEPTH][MAXLEN];
    int          dict_len [DEPTH];
    logic [31:0] dict_count [DEPTH];
    int          dict_used = 0;
    logic [31:0] word_tally = 0;
    word_result_t pending_results [$];

    int  errors = 0;
    bit  tx_no_gaps = 0;
    bit  rx_no_stalls = 0;
    bit  rx_hold_long = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    function automatic logic [31:0] sat_add(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic close_word();
        word_result_t r;
        int hit;
        bit same;
        hit = -1;
        r = '0;
        word_tally = sat_add(word_tally);
        for (int k = 0; k < dict_used && hit < 0; k++) begin
            if (dict_len[k] == pend_len) begin
                same = 1;
                for (int j = 0; j < pend_len; j++)
                    if (dict_chars[k][j] != pend_word[j]) same = 0;
                if (same) hit = k;
            end
        end
        if (hit >= 0) begin
            dict_count[hit] = sat_add(dict_count[hit]);
            r.entry_index = hit[5:0];
            r.entry_count = dict_count[hit];
        end else if (dict_used < DEPTH) begin
            for (int j = 0; j < pend_len; j++) dict_chars[dict_used][j] = pend_word[j];
            dict_len[dict_used] = pend_len;
            dict_count[dict_used] = 32'd1;
            r.entry_index = dict_used[5:0];
            r.entry_count = 32'd1;
            r.is_new = 1'b1;
            dict_used++;
        end else begin
            r.table_full = 1'b1;
        end
        r.word_truncated = pend_cut;
        r.total_words = word_tally;
        pending_results.push_back(r);
        pend_len = 0;
        pend_cut = 1'b0;
    endtask

    task automatic predict_byte(input logic [7:0] raw, input logic last);
        logic [7:0] b;
        b = raw;
        if (b >= UPPER_FIRST && b <= UPPER_LAST) b = b | LOWER_CASE_BIT;
        if (b == delim_a || b == delim_b || b == delim_c || b == NEWLINE_BYTE) begin
            if (pend_len > 0) close_word();
        end else begin
            if (pend_len < MAXLEN) begin
                pend_word[pend_len] = b;
                pend_len++;
            end else begin
                pend_cut = 1'b1;
            end
            if (last) close_word();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        bit taken;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= b;
        end_of_text <= last;
        do begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        predict_byte(b, last);
    endtask

    task automatic send_text(input string s, input logic last_on_end);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], last_on_end && (i == s.len() - 1));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_DELIM_FIRST:  delim_a = v;
            REG_DELIM_SECOND: delim_b = v;
            default:          delim_c = v;
        endcase
    endtask

    // output side: stall per result, optionally one long hold
    initial begin
        int n;
        bit fired;
        @(posedge rst_n);
        forever begin
            n = rx_no_stalls ? 0 : $urandom_range(0, 17);
            if (rx_hold_long) begin
                n = 600;
                rx_hold_long = 0;
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do begin
                @(negedge clk);
                fired = out_valid && !out_stall;
                @(posedge clk);
            end while (!fired);
        end
    end

    always @(negedge clk) begin
        word_result_t w;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report("unexpected result", {26'd0, entry_index}, 32'd0);
            end else begin
                w = pending_results.pop_front();
                if (entry_index !== w.entry_index)
                    report("entry_index", 32'(entry_index), 32'(w.entry_index));
                if (entry_count !== w.entry_count) report("entry_count", entry_count, w.entry_count);
                if (is_new !== w.is_new) report("is_new", 32'(is_new), 32'(w.is_new));
                if (word_truncated !== w.word_truncated)
                    report("word_truncated", 32'(word_truncated), 32'(w.word_truncated));
                if (table_full !== w.table_full)
                    report("table_full", 32'(table_full), 32'(w.table_full));
                if (total_words !== w.total_words) report("total_words", total_words, w.total_words);
            end
        end
    end

    task automatic test_directed();
        send_text("Hello, WORLD. hello\n", 0);
        send_text(" ,. \n\n", 0);
        send_text("@[AZaz`{", 0);
        send_byte(8'h00, 0);
        send_byte(8'hFF, 0);
        send_byte(8'h7F, 0);
        send_byte(8'h20, 0);
        send_text("abcdefghijklmnopqrstuvwxyz0123456789 ", 0);
        send_text("HELLO", 1);
        send_byte(8'h2E, 1);
        send_byte(8'h0A, 1);
        send_text("x", 1);
    endtask

    task automatic test_config();
        write_reg(REG_DELIM_FIRST, 8'h00);
        write_reg(REG_DELIM_SECOND, 8'hFF);
        write_reg(REG_DELIM_THIRD, 8'h61);
        send_text("q,r.s t", 0);
        send_byte(8'h00, 0);
        send_text("bAnAnA", 0);
        send_byte(8'hFF, 0);
        send_byte(8'h00, 1);
        write_reg(REG_DELIM_FIRST, 8'h2C);
        write_reg(REG_DELIM_SECOND, 8'h2E);
        write_reg(REG_DELIM_THIRD, 8'h20);
    endtask

    task automatic send_random_words(input int count, input int vocab_size);
        string vocab [$];
        string s;
        int len;
        byte c;
        for (int v = 0; v < vocab_size; v++) begin
            s = "";
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 34) : $urandom_range(1, 6);
            for (int j = 0; j < len; j++) begin
                c = 8'(8'h61 + $urandom_range(0, 25));
                if ($urandom_range(0, 1)) c = c & 8'hDF;
                s = {s, string'(c)};
            end
            vocab.push_back(s);
        end
        for (int i = 0; i < count; i++) begin
            s = vocab[$urandom_range(0, vocab_size - 1)];
            if ($urandom_range(0, 9) == 0) begin
                send_text(s, 1);
            end else begin
                send_text(s, 0);
                repeat ($urandom_range(1, 2)) begin
                    case ($urandom_range(0, 3))
                        0: send_byte(8'h2C, 0);
                        1: send_byte(8'h2E, 0);
                        2: send_byte(8'h20, 0);
                        default: send_byte(NEWLINE_BYTE, 0);
                    endcase
                end
            end
        end
    endtask

    task automatic test_random_words();
        send_random_words(60, 20);
        tx_no_gaps = 1;
        rx_no_stalls = 1;
        send_random_words(30, 20);
        tx_no_gaps = 0;
        rx_no_stalls = 0;
        drain();
    endtask

    task automatic test_backpressure();
        tx_no_gaps = 1;
        rx_hold_long = 1;
        send_random_words(25, 8);
        tx_no_gaps = 0;
        drain();
    endtask

    task automatic test_table_full();
        for (int i = 0; i <= DEPTH + 4; i++) begin
            send_byte(8'h6A, 0);
            send_byte(8'(8'h61 + i % 26), 0);
            send_byte(8'(8'h61 + i / 26), 0);
            send_byte(8'h20, 0);
        end
        send_text("jaa jzz ", 0);
        drain();
    endtask

    task automatic test_noise();
        for (int i = 0; i < 120; i++)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
        drain();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config();
        test_random_words();
        test_backpressure();
        test_table_full();
        test_noise();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #80000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule
